// ----- src/dtpg_pkg.sv -----
// package for the display test pattern generator: geometry constants and colour tables
`timescale 1ns / 1ps

package dtpg_pkg;

  localparam int WIDTH  = 480;
  localparam int HEIGHT = 272;
  localparam int MARGIN = 20;
  localparam int BAR_W  = WIDTH / 7;

  // internal coordinate width, holds sums of a coordinate and a screen size
  localparam int CW = 13;
  localparam int XW = 9;

  typedef logic [CW-1:0] coord_t;
  typedef logic [2:0]    bar_idx_t;

  localparam int TIER1   = (HEIGHT * 67) / 100;
  localparam int TIER2   = (HEIGHT * 75) / 100;
  localparam int SPLIT_I = (BAR_W * 5) / 4;
  localparam int SPLIT_W = (BAR_W * 5) / 2;
  localparam int SPLIT_Q = (BAR_W * 15) / 4;
  localparam int SPLIT_B = BAR_W * 5;
  localparam int SPLIT_P = BAR_W * 6;
  localparam int STRIPE  = BAR_W / 3;

  localparam int NUM_BARS = 7;

  function automatic logic [15:0] pack565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pack565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] top_bar(bar_idx_t idx);
    case (idx)
      3'd0:    top_bar = pack565(8'd192, 8'd192, 8'd192);
      3'd1:    top_bar = pack565(8'd192, 8'd192, 8'd0);
      3'd2:    top_bar = pack565(8'd0,   8'd192, 8'd192);
      3'd3:    top_bar = pack565(8'd0,   8'd192, 8'd0);
      3'd4:    top_bar = pack565(8'd192, 8'd0,   8'd192);
      3'd5:    top_bar = pack565(8'd192, 8'd0,   8'd0);
      default: top_bar = pack565(8'd0,   8'd0,   8'd192);
    endcase
  endfunction

  function automatic logic [15:0] mid_bar(bar_idx_t idx);
    case (idx)
      3'd0:    mid_bar = pack565(8'd0,   8'd0,   8'd192);
      3'd1:    mid_bar = pack565(8'd0,   8'd0,   8'd0);
      3'd2:    mid_bar = pack565(8'd192, 8'd0,   8'd192);
      3'd3:    mid_bar = pack565(8'd0,   8'd0,   8'd0);
      3'd4:    mid_bar = pack565(8'd0,   8'd192, 8'd192);
      3'd5:    mid_bar = pack565(8'd0,   8'd0,   8'd0);
      default: mid_bar = pack565(8'd192, 8'd192, 8'd192);
    endcase
  endfunction

endpackage

// ----- src/display_test_pattern_generator.sv -----
// top level: pixel coordinate in, rgb565 test pattern colour out
`timescale 1ns / 1ps

// Usage: drive x_i/y_i with a pixel coordinate and pulse start; busy is
// always low, so a coordinate may be issued on every clock. Each accepted
// beat is latched into an input register, coloured by one level of compare
// logic and latched into the result register: pixel_rgb565_o is shown with
// strobe_o high for exactly one cycle, once the beat has passed both the
// input and the result register. Throughput is one pixel per cycle. The
// receiver cannot stall: every result is shown once and then replaced by
// the next one. Pattern choice comes from an APB-style register at
// addresses 0 to 3, as only paddr[2] is decoded (bit 0: 0 calibration
// card, 1 colour bars); write it only while no pixel is in flight. Reset
// clears the pattern select to the calibration card and drops any pixels
// in flight; there is no clearing pass.
module display_test_pattern_generator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [dtpg_pkg::XW-1:0]   x_i,
  input  logic [dtpg_pkg::XW-1:0]   y_i,
  output logic                      strobe_o,
  output logic [15:0]               pixel_rgb565_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam dtpg_pkg::coord_t C_W    = dtpg_pkg::coord_t'(dtpg_pkg::WIDTH);
  localparam dtpg_pkg::coord_t C_H    = dtpg_pkg::coord_t'(dtpg_pkg::HEIGHT);
  localparam dtpg_pkg::coord_t C_M    = dtpg_pkg::coord_t'(dtpg_pkg::MARGIN);
  localparam dtpg_pkg::coord_t C_W_M  = dtpg_pkg::coord_t'(dtpg_pkg::WIDTH - dtpg_pkg::MARGIN);
  localparam dtpg_pkg::coord_t C_H_M  = dtpg_pkg::coord_t'(dtpg_pkg::HEIGHT - dtpg_pkg::MARGIN);
  localparam dtpg_pkg::coord_t C_W2   = dtpg_pkg::coord_t'(2 * dtpg_pkg::WIDTH);
  localparam dtpg_pkg::coord_t C_T1   = dtpg_pkg::coord_t'(dtpg_pkg::TIER1);
  localparam dtpg_pkg::coord_t C_T2   = dtpg_pkg::coord_t'(dtpg_pkg::TIER2);
  localparam dtpg_pkg::coord_t C_SI   = dtpg_pkg::coord_t'(dtpg_pkg::SPLIT_I);
  localparam dtpg_pkg::coord_t C_SW   = dtpg_pkg::coord_t'(dtpg_pkg::SPLIT_W);
  localparam dtpg_pkg::coord_t C_SQ   = dtpg_pkg::coord_t'(dtpg_pkg::SPLIT_Q);
  localparam dtpg_pkg::coord_t C_SB   = dtpg_pkg::coord_t'(dtpg_pkg::SPLIT_B);
  localparam dtpg_pkg::coord_t C_SP   = dtpg_pkg::coord_t'(dtpg_pkg::SPLIT_P);
  localparam dtpg_pkg::coord_t C_PL1  =
    dtpg_pkg::coord_t'(dtpg_pkg::SPLIT_B + dtpg_pkg::STRIPE);
  localparam dtpg_pkg::coord_t C_PL2  =
    dtpg_pkg::coord_t'(dtpg_pkg::SPLIT_B + 2 * dtpg_pkg::STRIPE);

  // register file
  logic sel_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = {31'd0, sel_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (cfg_wr) begin
      sel_q <= pwdata[0];
    end
  end

  // input register
  logic                    vld_q;
  logic [dtpg_pkg::XW-1:0] x_q;
  logic [dtpg_pkg::XW-1:0] y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      x_q <= x_i;
      y_q <= y_i;
    end
  end

  // colour logic
  dtpg_pkg::coord_t   xw;
  dtpg_pkg::coord_t   yw;
  dtpg_pkg::coord_t   x3;
  logic               in_v;
  logic               in_h;
  logic [15:0]        card_pix;
  logic [15:0]        bars_pix;
  dtpg_pkg::bar_idx_t bar_idx;

  assign xw   = dtpg_pkg::coord_t'(x_q);
  assign yw   = dtpg_pkg::coord_t'(y_q);
  assign x3   = (xw << 1) + xw;
  assign in_v = (yw > C_M) && (yw < C_H_M);
  assign in_h = (xw > C_M) && (xw < C_W_M);

  always_comb begin
    if (xw < C_M && yw < C_M) begin
      card_pix = dtpg_pkg::pack565(8'd255, 8'd255, 8'd255);
    end else if (xw < C_M && in_v) begin
      card_pix = dtpg_pkg::pack565(8'd0, 8'd0, 8'd255);
    end else if (yw < C_M && in_h) begin
      card_pix = dtpg_pkg::pack565(8'd0, 8'd255, 8'd0);
    end else if (xw > C_W_M && in_v) begin
      card_pix = dtpg_pkg::pack565(8'd255, 8'd0, 8'd0);
    end else if (yw > C_H_M && in_h) begin
      card_pix = dtpg_pkg::pack565(8'd255, 8'd255, 8'd0);
    end else if (xw == C_M || xw == C_W_M || yw == C_M || yw == C_H_M) begin
      card_pix = dtpg_pkg::pack565(8'd255, 8'd255, 8'd255);
    end else if (xw == yw || (xw + C_H) == (yw + C_W)) begin
      // second diagonal: x - y == w - h, rearranged to stay unsigned
      card_pix = dtpg_pkg::pack565(8'd255, 8'd0, 8'd255);
    end else if ((xw + yw) == C_W || (xw + yw) == C_H) begin
      card_pix = dtpg_pkg::pack565(8'd0, 8'd255, 8'd255);
    end else if (in_h && in_v) begin
      // thirds of the width: floor(3x/w) compared without a divider
      if (x3 < C_W) begin
        card_pix = dtpg_pkg::pack565(8'd0, 8'd0, y_q[7:0]);
      end else if (x3 < C_W2) begin
        card_pix = dtpg_pkg::pack565(8'd0, y_q[7:0], 8'd0);
      end else begin
        card_pix = dtpg_pkg::pack565(y_q[7:0], 8'd0, 8'd0);
      end
    end else begin
      card_pix = 16'd0;
    end
  end

  // bar index, saturating at the last bar
  always_comb begin
    bar_idx = '0;
    for (int k = 1; k < dtpg_pkg::NUM_BARS; k++) begin
      if (xw >= dtpg_pkg::coord_t'(k * dtpg_pkg::BAR_W)) begin
        bar_idx = dtpg_pkg::bar_idx_t'(k);
      end
    end
  end

  always_comb begin
    if (yw < C_T1) begin
      bars_pix = dtpg_pkg::top_bar(bar_idx);
    end else if (yw < C_T2) begin
      bars_pix = dtpg_pkg::mid_bar(bar_idx);
    end else if (xw < C_SI) begin
      bars_pix = dtpg_pkg::pack565(8'd0, 8'd33, 8'd76);
    end else if (xw < C_SW) begin
      bars_pix = dtpg_pkg::pack565(8'd255, 8'd255, 8'd255);
    end else if (xw < C_SQ) begin
      bars_pix = dtpg_pkg::pack565(8'd56, 8'd0, 8'd110);
    end else if (xw < C_SB) begin
      bars_pix = dtpg_pkg::pack565(8'd19, 8'd19, 8'd19);
    end else if (xw < C_SP) begin
      // pluge stripes
      if (xw < C_PL1) begin
        bars_pix = dtpg_pkg::pack565(8'd11, 8'd11, 8'd11);
      end else if (xw < C_PL2) begin
        bars_pix = dtpg_pkg::pack565(8'd19, 8'd19, 8'd19);
      end else begin
        bars_pix = dtpg_pkg::pack565(8'd27, 8'd27, 8'd27);
      end
    end else begin
      bars_pix = dtpg_pkg::pack565(8'd19, 8'd19, 8'd19);
    end
  end

  // result register
  logic        strobe_q;
  logic [15:0] pix_q;
  logic [15:0] pix_d;

  assign pix_d = sel_q ? bars_pix : card_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      pix_q <= pix_d;
    end
  end

  assign strobe_o       = strobe_q;
  assign pixel_rgb565_o = pix_q;

endmodule

// ----- src/dtpg_checker.sv -----
// port-level checker for the display test pattern generator, with its bind
`timescale 1ns / 1ps

module dtpg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        strobe_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // every accepted beat gives one result, after the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 strobe_o)
    else $error("accepted beat produced no result");

  // no result without an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!start || busy) |-> ##2 !strobe_o)
    else $error("result without accepted beat");

  // pattern select reads back what was written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[2] == 1'b0) |=>
      (prdata[0] == $past(pwdata[0])))
    else $error("pattern select readback mismatch");

  // select holds when no write hits it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(psel && penable && pwrite && pready && paddr[2] == 1'b0) |=> $stable(prdata))
    else $error("pattern select changed without write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && (prdata[31:1] == 31'd0))
    else $error("apb ready low or unused read bits set");

endmodule

bind display_test_pattern_generator dtpg_checker u_dtpg_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe_o (strobe_o),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata),
  .pready   (pready)
);
